>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the block pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define MSBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define MSBP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define MSBP_ASSERT(lbl, prop, msg)
`define MSBP_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> rtl/core/msbp_pkg.sv
// Constants, types and codes of the multi-stack block pool.
package msbp_pkg;

  localparam int unsigned STACKS        = 1024;
  localparam int unsigned BLOCK_ENTRIES = 8;
  localparam int unsigned POOL_BLOCKS   = 4096;
  localparam int unsigned WORD_BITS     = 32;

  // STACKS, BLOCK_ENTRIES and POOL_BLOCKS are powers of two
  localparam int unsigned SID_W   = $clog2(STACKS);
  localparam int unsigned BLK_W   = $clog2(POOL_BLOCKS);
  localparam int unsigned FILL_W  = $clog2(BLOCK_ENTRIES + 1);
  localparam int unsigned SLOT_W  = $clog2(BLOCK_ENTRIES);
  localparam int unsigned ENT_W   = BLK_W + SLOT_W;
  localparam int unsigned NFB_W   = BLK_W + 1;
  localparam int unsigned ENTRIES = POOL_BLOCKS * BLOCK_ENTRIES;

  // Fixed port field widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POP_W    = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH  = 2'd0,
    ST_POP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STK,
    S_BLK,
    S_FWD,
    S_BACK,
    S_ALLOC,
    S_DONE
  } state_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Per-stack descriptor
  typedef struct packed {
    logic             held;
    logic [BLK_W-1:0] cur;
    logic [BLK_W-1:0] high;
  } stk_word_t;

  // Per-block descriptor
  typedef struct packed {
    logic [SID_W-1:0]  owner;
    logic [FILL_W-1:0] fill;
  } blk_word_t;

  localparam int unsigned STK_BITS = 1 + 2 * BLK_W;
  localparam int unsigned BLKD_BITS = SID_W + FILL_W;

  typedef struct packed {
    logic             we;
    logic [SID_W-1:0] waddr;
    stk_word_t        wdata;
    logic             re;
    logic [SID_W-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    blk_word_t        wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } blk_req_t;

  typedef struct packed {
    logic             we;
    logic [ENT_W-1:0] waddr;
    word_t            wdata;
    logic             re;
    logic [ENT_W-1:0] raddr;
  } ent_req_t;

endpackage

>>> rtl/core/msbp_if.sv
// Valid/ready channel interfaces for requests and results.
interface msbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [msbp_pkg::OP_W-1:0]   operation;
  logic [msbp_pkg::ID_W-1:0]   stack_id;
  logic [msbp_pkg::VAL_W-1:0]  push_value;

  modport source (output valid, output operation, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input operation, input stack_id, input push_value,
                  output ready);
endinterface

interface msbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [msbp_pkg::POP_W-1:0]     pop_value;
  logic [msbp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

>>> rtl/core/msbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msbp_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/msbp_ctrl.sv
// Sequencer: stack/block table walks, allocation and the result register.
`include "assert_macros.svh"

module msbp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  msbp_in_if.sink             in_i,
  msbp_out_if.source          out_o,
  output msbp_pkg::stk_req_t  stk_req_o,
  input  msbp_pkg::stk_word_t stk_rdata_i,
  output msbp_pkg::blk_req_t  blk_req_o,
  input  msbp_pkg::blk_word_t blk_rdata_i,
  output msbp_pkg::ent_req_t  ent_req_o,
  input  msbp_pkg::word_t     ent_rdata_i
);

  localparam logic [msbp_pkg::FILL_W-1:0] FULL_FILL =
    msbp_pkg::FILL_W'(msbp_pkg::BLOCK_ENTRIES);

  msbp_pkg::state_e  state_q, state_d;
  logic [msbp_pkg::SID_W-1:0] clr_q, clr_d;
  logic [msbp_pkg::NFB_W-1:0] nfb_q, nfb_d;
  logic                       out_valid_q, out_valid_d;

  msbp_pkg::op_e              op_q, op_d;
  logic [msbp_pkg::SID_W-1:0] sid_q, sid_d;
  msbp_pkg::word_t            val_q, val_d;
  logic [msbp_pkg::BLK_W-1:0] cur_q, cur_d;
  logic [msbp_pkg::BLK_W-1:0] high_q, high_d;
  logic [msbp_pkg::BLK_W-1:0] blk_q, blk_d;
  msbp_pkg::status_e          st_q, st_d;
  logic [msbp_pkg::POP_W-1:0] pop_value_q, pop_value_d;
  msbp_pkg::status_e          status_q, status_d;

  // shared step unit: next/previous block index of the walk
  logic [msbp_pkg::NFB_W-1:0] step_base;
  logic [msbp_pkg::NFB_W-1:0] step_inc;
  logic [msbp_pkg::BLK_W-1:0] step_dec;
  logic                       step_past_high;

  // common push write
  logic                        push_go;
  logic [msbp_pkg::BLK_W-1:0]  wr_blk;
  logic [msbp_pkg::FILL_W-1:0] wr_fill;
  logic [msbp_pkg::BLK_W-1:0]  wr_high;

  always_comb begin
    step_base      = (state_q == msbp_pkg::S_BLK) ? {1'b0, cur_q} : {1'b0, blk_q};
    step_inc       = step_base + 1'b1;
    step_dec       = step_base[msbp_pkg::BLK_W-1:0] - 1'b1;
    step_past_high = step_inc > {1'b0, high_q};
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    nfb_d       = nfb_q;
    op_d        = op_q;
    sid_d       = sid_q;
    val_d       = val_q;
    cur_d       = cur_q;
    high_d      = high_q;
    blk_d       = blk_q;
    st_d        = st_q;
    pop_value_d = pop_value_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    in_i.ready  = 1'b0;
    stk_req_o   = '0;
    blk_req_o   = '0;
    ent_req_o   = '0;
    push_go     = 1'b0;
    wr_blk      = cur_q;
    wr_fill     = '0;
    wr_high     = high_q;

    case (state_q)
      msbp_pkg::S_CLEAR: begin
        stk_req_o.we    = 1'b1;
        stk_req_o.waddr = clr_q;
        clr_d           = clr_q + 1'b1;
        if (clr_q == msbp_pkg::SID_W'(msbp_pkg::STACKS - 1)) begin
          state_d = msbp_pkg::S_IDLE;
        end
      end

      msbp_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d            = msbp_pkg::op_e'(in_i.operation);
          sid_d           = msbp_pkg::SID_W'(in_i.stack_id);
          val_d           = msbp_pkg::word_t'(in_i.push_value);
          stk_req_o.re    = 1'b1;
          stk_req_o.raddr = msbp_pkg::SID_W'(in_i.stack_id);
          state_d         = msbp_pkg::S_STK;
        end
      end

      msbp_pkg::S_STK: begin
        cur_d  = stk_rdata_i.cur;
        high_d = stk_rdata_i.high;
        if (!stk_rdata_i.held) begin
          if (op_q == msbp_pkg::OP_PUSH) begin
            state_d = msbp_pkg::S_ALLOC;
          end else begin
            st_d    = msbp_pkg::ST_EMPTY;
            state_d = msbp_pkg::S_DONE;
          end
        end else begin
          blk_req_o.re    = 1'b1;
          blk_req_o.raddr = stk_rdata_i.cur;
          state_d         = msbp_pkg::S_BLK;
        end
      end

      msbp_pkg::S_BLK: begin
        if (op_q == msbp_pkg::OP_PUSH) begin
          if (blk_rdata_i.fill < FULL_FILL) begin
            push_go = 1'b1;
            wr_blk  = cur_q;
            wr_fill = blk_rdata_i.fill;
          end else if (step_past_high) begin
            state_d = msbp_pkg::S_ALLOC;
          end else begin
            blk_d           = step_inc[msbp_pkg::BLK_W-1:0];
            blk_req_o.re    = 1'b1;
            blk_req_o.raddr = step_inc[msbp_pkg::BLK_W-1:0];
            state_d         = msbp_pkg::S_FWD;
          end
        end else if (blk_rdata_i.fill == '0) begin
          st_d    = msbp_pkg::ST_EMPTY;
          state_d = msbp_pkg::S_DONE;
        end else begin
          ent_req_o.re          = 1'b1;
          ent_req_o.raddr       = {cur_q, msbp_pkg::SLOT_W'(blk_rdata_i.fill - 1'b1)};
          blk_req_o.we          = 1'b1;
          blk_req_o.waddr       = cur_q;
          blk_req_o.wdata.owner = blk_rdata_i.owner;
          blk_req_o.wdata.fill  = blk_rdata_i.fill - 1'b1;
          st_d                  = msbp_pkg::ST_POP;
          // block now empty: walk back to the previous block of this stack
          if (blk_rdata_i.fill == msbp_pkg::FILL_W'(1) && cur_q != '0) begin
            blk_d           = step_dec;
            blk_req_o.re    = 1'b1;
            blk_req_o.raddr = step_dec;
            state_d         = msbp_pkg::S_BACK;
          end else begin
            state_d = msbp_pkg::S_DONE;
          end
        end
      end

      msbp_pkg::S_FWD: begin
        if (blk_rdata_i.owner == sid_q && blk_rdata_i.fill < FULL_FILL) begin
          push_go = 1'b1;
          wr_blk  = blk_q;
          wr_fill = blk_rdata_i.fill;
        end else if (step_past_high) begin
          state_d = msbp_pkg::S_ALLOC;
        end else begin
          blk_d           = step_inc[msbp_pkg::BLK_W-1:0];
          blk_req_o.re    = 1'b1;
          blk_req_o.raddr = step_inc[msbp_pkg::BLK_W-1:0];
        end
      end

      msbp_pkg::S_BACK: begin
        if (blk_rdata_i.owner == sid_q) begin
          stk_req_o.we         = 1'b1;
          stk_req_o.waddr      = sid_q;
          stk_req_o.wdata.held = 1'b1;
          stk_req_o.wdata.cur  = blk_q;
          stk_req_o.wdata.high = high_q;
          state_d              = msbp_pkg::S_DONE;
        end else if (blk_q == '0) begin
          // no earlier block: the stack keeps its empty block
          state_d = msbp_pkg::S_DONE;
        end else begin
          blk_d           = step_dec;
          blk_req_o.re    = 1'b1;
          blk_req_o.raddr = step_dec;
        end
      end

      msbp_pkg::S_ALLOC: begin
        if (nfb_q >= msbp_pkg::NFB_W'(msbp_pkg::POOL_BLOCKS)) begin
          st_d    = msbp_pkg::ST_FULL;
          state_d = msbp_pkg::S_DONE;
        end else begin
          push_go = 1'b1;
          wr_blk  = nfb_q[msbp_pkg::BLK_W-1:0];
          wr_fill = '0;
          wr_high = nfb_q[msbp_pkg::BLK_W-1:0];
          nfb_d   = nfb_q + 1'b1;
        end
      end

      msbp_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          status_d    = st_q;
          pop_value_d = (st_q == msbp_pkg::ST_POP) ?
                        msbp_pkg::POP_W'(ent_rdata_i) : '0;
          state_d     = msbp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = msbp_pkg::S_IDLE;
      end
    endcase

    if (push_go) begin
      ent_req_o.we          = 1'b1;
      ent_req_o.waddr       = {wr_blk, wr_fill[msbp_pkg::SLOT_W-1:0]};
      ent_req_o.wdata       = val_q;
      blk_req_o.we          = 1'b1;
      blk_req_o.waddr       = wr_blk;
      blk_req_o.wdata.owner = sid_q;
      blk_req_o.wdata.fill  = wr_fill + 1'b1;
      stk_req_o.we          = 1'b1;
      stk_req_o.waddr       = sid_q;
      stk_req_o.wdata.held  = 1'b1;
      stk_req_o.wdata.cur   = wr_blk;
      stk_req_o.wdata.high  = wr_high;
      st_d                  = msbp_pkg::ST_PUSH;
      state_d               = msbp_pkg::S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msbp_pkg::S_CLEAR;
      clr_q       <= '0;
      nfb_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nfb_q       <= nfb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    sid_q       <= sid_d;
    val_q       <= val_d;
    cur_q       <= cur_d;
    high_q      <= high_d;
    blk_q       <= blk_d;
    st_q        <= st_d;
    pop_value_q <= pop_value_d;
    status_q    <= status_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pop_value = pop_value_q;
  assign out_o.status    = status_q;

  `MSBP_ASSERT_NEVER(a_nfb_range, nfb_q > msbp_pkg::NFB_W'(msbp_pkg::POOL_BLOCKS), "block pointer past pool")
  `MSBP_ASSERT(a_nfb_step, (nfb_q != $past(nfb_q)) |-> (nfb_q == $past(nfb_q) + 1'b1), "block pointer jumped")
  `MSBP_ASSERT(a_ent_write_push, ent_req_o.we |-> (op_q == msbp_pkg::OP_PUSH), "entry written on pop")
  `MSBP_ASSERT(a_fill_bound, blk_req_o.we |-> (blk_req_o.wdata.fill <= FULL_FILL), "block overfilled")
  `MSBP_ASSERT(a_fwd_bound, (state_q == msbp_pkg::S_FWD) |-> (blk_q <= high_q), "forward walk past newest block")

endmodule

>>> rtl/core/multi_stack_block_pool.sv
// Top level of the multi-stack block pool: tables, entry memory and sequencer.
// Many LIFO stacks share one word memory cut into fixed blocks that a bump pointer hands out
// and never frees. Each request (push or pop on one stack) gives exactly one result with
// status push done, pop done, pop on empty stack or pool full. One request is handled at a
// time: a push into a block with room or a pop that leaves its block non-empty goes from
// transfer in to result valid through a stack table read, a block table read and update and
// a result load, and the next request can transfer once the result is loaded. A pop on a
// stack that holds no block skips the block table read. A push onto a full block first walks
// forward block by block from the current block toward the stack's newest block and takes a
// fresh allocation if none has room; a pop that empties its block walks back block by block
// until an earlier block of the same stack is found or block 0 is reached. The walks are bound
// by the block table's single read port, one block per cycle. A result that is not taken holds
// the next result load until it transfers. After reset the block clears its stack table, one
// stack per cycle, and takes no request until the clear ends.
module multi_stack_block_pool (
  input  logic       clk_i,
  input  logic       rst_ni,
  msbp_in_if.sink    in_i,
  msbp_out_if.source out_o
);

  msbp_pkg::stk_req_t  stk_req;
  msbp_pkg::stk_word_t stk_rdata;
  msbp_pkg::blk_req_t  blk_req;
  msbp_pkg::blk_word_t blk_rdata;
  msbp_pkg::ent_req_t  ent_req;
  msbp_pkg::word_t     ent_rdata;

  msbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .stk_req_o   (stk_req),
    .stk_rdata_i (stk_rdata),
    .blk_req_o   (blk_req),
    .blk_rdata_i (blk_rdata),
    .ent_req_o   (ent_req),
    .ent_rdata_i (ent_rdata)
  );

  msbp_ram #(
    .DEPTH (msbp_pkg::STACKS),
    .WIDTH (msbp_pkg::STK_BITS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_req.we),
    .waddr_i (stk_req.waddr),
    .wdata_i (stk_req.wdata),
    .re_i    (stk_req.re),
    .raddr_i (stk_req.raddr),
    .rdata_o (stk_rdata)
  );

  msbp_ram #(
    .DEPTH (msbp_pkg::POOL_BLOCKS),
    .WIDTH (msbp_pkg::BLKD_BITS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_req.we),
    .waddr_i (blk_req.waddr),
    .wdata_i (blk_req.wdata),
    .re_i    (blk_req.re),
    .raddr_i (blk_req.raddr),
    .rdata_o (blk_rdata)
  );

  msbp_ram #(
    .DEPTH (msbp_pkg::ENTRIES),
    .WIDTH (msbp_pkg::WORD_BITS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_req.we),
    .waddr_i (ent_req.waddr),
    .wdata_i (ent_req.wdata),
    .re_i    (ent_req.re),
    .raddr_i (ent_req.raddr),
    .rdata_o (ent_rdata)
  );

endmodule

>>> dv/tb_multi_stack_block_pool.sv
// Self-checking testbench of the multi-stack block pool: directed table and random mix.
`timescale 1ns / 1ps

module tb_multi_stack_block_pool;

  localparam int unsigned IDLE_PCT    = 14;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned HOT_N       = 6;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN       = 200;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DIR_N       = 24;
  // every transfer bounded by a full-pool walk plus gaps and stalls
  localparam longint unsigned ITEM_BOUND = 64'(DIR_N + RAND_ITEMS);
  localparam longint unsigned ITEM_WORST = 64'(msbp_pkg::POOL_BLOCKS) + 64'd96;
  localparam longint unsigned LIMIT      = 64'd4 * ITEM_BOUND * ITEM_WORST
                                           + 64'(HOLD_CYCLES) + 64'(DRAIN)
                                           + 64'd4 * 64'(msbp_pkg::STACKS);

  typedef logic [msbp_pkg::BLK_W:0]    cur_t;
  typedef logic [msbp_pkg::BLK_W-1:0]  blk_t;
  typedef logic [msbp_pkg::SID_W-1:0]  sid_t;
  typedef logic [msbp_pkg::FILL_W-1:0] fill_t;
  typedef logic [msbp_pkg::ID_W-1:0]   id_t;
  typedef logic [msbp_pkg::VAL_W-1:0]  val_t;

  typedef struct packed {
    logic [msbp_pkg::POP_W-1:0] pop_value;
    msbp_pkg::status_e          status;
  } pool_result_t;

  typedef struct packed {
    msbp_pkg::op_e op;
    id_t           sid;
    val_t          val;
    logic          typed;
    pool_result_t  res;
  } dir_row_t;

  // typed rows carry their result; the rest go through the predictor
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{msbp_pkg::OP_POP,  10'd0,    32'hDEAD_BEEF, 1'b1, '{32'h0000_0000, msbp_pkg::ST_EMPTY}},
    '{msbp_pkg::OP_POP,  10'd1023, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, msbp_pkg::ST_EMPTY}},
    '{msbp_pkg::OP_PUSH, 10'd0,    32'h0000_0000, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd1023, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_POP,  10'd1023, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_POP,  10'd1023, 32'h5555_5555, 1'b1, '{32'h0000_0000, msbp_pkg::ST_EMPTY}},
    '{msbp_pkg::OP_PUSH, 10'd1023, 32'h1234_5678, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_POP,  10'd0,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0001, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0002, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0003, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0004, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0005, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0006, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0007, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'h0000_0008, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'hA5A5_A5A5, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_POP,  10'd5,    32'h0000_0000, 1'b0, '{32'h0000_0000, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_PUSH, 10'd5,    32'hAAAA_AAAA, 1'b0, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_POP,  10'd5,    32'h0000_0000, 1'b0, '{32'h0000_0000, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_POP,  10'd5,    32'h0000_0000, 1'b0, '{32'h0000_0000, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_PUSH, 10'd512,  32'h8000_0000, 1'b1, '{32'h0000_0000, msbp_pkg::ST_PUSH}},
    '{msbp_pkg::OP_POP,  10'd512,  32'h0000_0000, 1'b1, '{32'h8000_0000, msbp_pkg::ST_POP}},
    '{msbp_pkg::OP_POP,  10'd1023, 32'h0000_0000, 1'b0, '{32'h0000_0000, msbp_pkg::ST_POP}}
  };

  logic clk_i;
  logic rst_ni;

  msbp_in_if  in_if ();
  msbp_out_if out_if ();

  multi_stack_block_pool dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Pool model state
  cur_t            pool_cur   [msbp_pkg::STACKS];
  blk_t            pool_top   [msbp_pkg::STACKS];
  sid_t            pool_owner [msbp_pkg::POOL_BLOCKS];
  fill_t           pool_fill  [msbp_pkg::POOL_BLOCKS];
  msbp_pkg::word_t pool_word  [msbp_pkg::ENTRIES];
  logic [msbp_pkg::NFB_W-1:0] alloc_ptr;

  pool_result_t   pending_q [$];
  int unsigned    mismatches;
  int unsigned    results_seen;
  bit             calm;
  longint unsigned cycles;
  id_t            hot_ids [HOT_N];

  function automatic void pool_clear();
    for (int i = 0; i < msbp_pkg::STACKS; i++) begin
      pool_cur[i] = '1;
      pool_top[i] = '0;
    end
    for (int i = 0; i < msbp_pkg::POOL_BLOCKS; i++) begin
      pool_owner[i] = '0;
      pool_fill[i]  = '0;
    end
    for (int i = 0; i < msbp_pkg::ENTRIES; i++) pool_word[i] = '0;
    alloc_ptr = '0;
  endfunction

  // Applies one request to the pool model and returns its result.
  function automatic pool_result_t pool_apply(msbp_pkg::op_e op, id_t id, val_t val);
    pool_result_t res;
    int unsigned  sid, cur, top, b;
    bit           need_new, found;
    sid = int'(id) % msbp_pkg::STACKS;
    res.pop_value = '0;
    cur = int'(pool_cur[sid]);
    if (op == msbp_pkg::OP_PUSH) begin
      need_new = 1'b0;
      if (cur >= msbp_pkg::POOL_BLOCKS) begin
        need_new = 1'b1;
      end else if (pool_fill[cur] >= msbp_pkg::BLOCK_ENTRIES) begin
        // walk forward for an owned block with room
        top   = int'(pool_top[sid]);
        found = 1'b0;
        b     = cur + 1;
        while (b <= top && !found) begin
          if (pool_owner[b] == sid_t'(sid) && pool_fill[b] < msbp_pkg::BLOCK_ENTRIES)
            found = 1'b1;
          else b++;
        end
        if (found) cur = b;
        else need_new = 1'b1;
      end
      if (need_new && alloc_ptr >= msbp_pkg::POOL_BLOCKS) begin
        res.status = msbp_pkg::ST_FULL;
      end else begin
        if (need_new) begin
          cur             = int'(alloc_ptr);
          pool_owner[cur] = sid_t'(sid);
          pool_fill[cur]  = '0;
          pool_top[sid]   = blk_t'(cur);
          alloc_ptr       = alloc_ptr + 1'b1;
        end
        pool_word[cur * msbp_pkg::BLOCK_ENTRIES + int'(pool_fill[cur])] = val;
        pool_fill[cur] = pool_fill[cur] + 1'b1;
        pool_cur[sid]  = cur_t'(cur);
        res.status     = msbp_pkg::ST_PUSH;
      end
    end else begin
      if (cur >= msbp_pkg::POOL_BLOCKS || pool_fill[cur] == 0) begin
        res.status = msbp_pkg::ST_EMPTY;
      end else begin
        pool_fill[cur] = pool_fill[cur] - 1'b1;
        res.pop_value  = pool_word[cur * msbp_pkg::BLOCK_ENTRIES + int'(pool_fill[cur])];
        if (pool_fill[cur] == 0) begin
          // step back to the nearest earlier block of this stack, if any
          found = 1'b0;
          b     = cur;
          while (b > 0 && !found) begin
            if (pool_owner[b-1] == sid_t'(sid)) begin
              pool_cur[sid] = cur_t'(b - 1);
              found = 1'b1;
            end else begin
              b--;
            end
          end
        end
        res.status = msbp_pkg::ST_POP;
      end
    end
    return res;
  endfunction

  // Offers one request, waits for its transfer, then records the expected result.
  task automatic issue_op(input msbp_pkg::op_e op, input id_t id, input val_t val,
                          input bit typed, input pool_result_t typed_res,
                          output pool_result_t pred);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_if.valid      <= 1'b0;
      in_if.operation  <= msbp_pkg::OP_W'($urandom_range(0, 1));
      in_if.stack_id   <= msbp_pkg::ID_W'($urandom);
      in_if.push_value <= msbp_pkg::VAL_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.stack_id   <= id;
    in_if.push_value <= val;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = pool_apply(op, id, val);
    pending_q.push_back(typed ? typed_res : pred);
  endtask

  function automatic id_t pick_stack();
    if ($urandom_range(0, 99) < 15) return msbp_pkg::ID_W'($urandom);
    return hot_ids[$urandom_range(0, HOT_N - 1)];
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return msbp_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Timeout watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: checks each transfer, idles at random, holds off once for a long stretch
  initial begin
    pool_result_t exp;
    int unsigned  hold_left;
    bit           held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: pop_value %h status %0d",
                     out_if.pop_value, out_if.status);
        end else begin
          exp = pending_q.pop_front();
          if (out_if.pop_value !== exp.pop_value || out_if.status !== exp.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d mismatch: expected pop_value %h status %0d, got %h %0d",
                       results_seen, exp.pop_value, exp.status,
                       out_if.pop_value, out_if.status);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_if.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Request side
  initial begin
    pool_result_t pred;
    pool_result_t none;
    int unsigned  push_pct;
    mismatches   = 0;
    results_seen = 0;
    calm         = 1'b0;
    none         = '{'0, msbp_pkg::ST_PUSH};
    pool_clear();
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= msbp_pkg::OP_PUSH;
    in_if.stack_id   <= '0;
    in_if.push_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no request is taken until the stack table clear ends; the handshake covers it
    for (int k = 0; k < DIR_N; k++)
      issue_op(DIRECTED[k].op, DIRECTED[k].sid, DIRECTED[k].val,
               DIRECTED[k].typed, DIRECTED[k].res, pred);

    // Random mix on a few hot stacks so stacks span several blocks and walk both ways
    for (int k = 0; k < HOT_N; k++) hot_ids[k] = msbp_pkg::ID_W'($urandom);
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      calm     = (i >= 500 && i < 700);
      push_pct = ((i / 120) % 2 == 0) ? 72 : 30;
      if ($urandom_range(0, 99) < push_pct)
        issue_op(msbp_pkg::OP_PUSH, pick_stack(), pick_value(), 1'b0, none, pred);
      else
        issue_op(msbp_pkg::OP_POP, pick_stack(), msbp_pkg::VAL_W'($urandom), 1'b0, none,
                 pred);
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
